// ===== rtl/lebc_pkg.sv =====
package lebc_pkg;

	// Number of register stages from input capture to the output register.
	localparam int NumStages = 51;

	// Stage map of the pipeline.
	localparam int StgLoad   = 0;
	localparam int StgPrep   = 1;
	localparam int StgRemLo  = 2;
	localparam int StgRemHi  = 33;
	localparam int StgQSetup = 34;
	localparam int StgQLo    = 35;
	localparam int StgQHi    = 42;
	localparam int StgTri    = 43;
	localparam int StgEase   = 44;
	localparam int StgScale  = 45;
	localparam int StgLevel  = 46;
	localparam int StgProd   = 47;
	localparam int StgEnv    = 48;
	localparam int StgBlend  = 49;
	localparam int StgOut    = 50;

	localparam logic [6:0] MixMax = 7'd100;

	typedef enum logic [2:0] {
		KIND_OFF,
		KIND_SOLID,
		KIND_BREATH,
		KIND_SHALLOW,
		KIND_PULSE,
		KIND_RISE,
		KIND_PRESS,
		KIND_UNUSED
	} kind_t;

	typedef enum logic {
		REG_MIX
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [7:0]  phase;
		logic [31:0] elapsed;
		logic [7:0]  atm;
		logic [11:0] period;
		logic [19:0] dur;
		logic [16:0] rise;
		logic [31:0] dvd;
		logic [11:0] rem;
		logic [27:0] num;
		logic [19:0] den;
		logic [7:0]  quo;
		logic        zero;
		logic        pact;
		logic [15:0] pmul;
		logic [7:0]  pidx;
		logic [15:0] sq;
		logic [7:0]  ease;
		logic [15:0] scl;
		logic [7:0]  lvl;
		logic [15:0] prod;
		logic [7:0]  env;
		logic [14:0] blend;
		logic [7:0]  res;
	} item_t;

	// Exact x/255 for x below 65280 by a reciprocal multiply.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'(65794);
		return p[31:24];
	endfunction

	// Exact x/100 for x up to 25500.
	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'(167773);
		return p[31:24];
	endfunction

	function automatic logic [7:0] tri8(input logic [7:0] p);
		logic [7:0] q;
		q = p[7] ? (8'd255 - p) : p;
		return {q[6:0], 1'b0};
	endfunction

endpackage

// ===== rtl/lebc_if.sv =====
interface lebc_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  effect_kind;
	logic [7:0]  peak_value;
	logic [7:0]  speed;
	logic [7:0]  phase_offset;
	logic [15:0] duration_cs;
	logic [31:0] elapsed_ms;
	logic [7:0]  atmosphere_level;

	modport source(output valid, effect_kind, peak_value, speed, phase_offset,
		duration_cs, elapsed_ms, atmosphere_level, input ready);
	modport sink(input valid, effect_kind, peak_value, speed, phase_offset,
		duration_cs, elapsed_ms, atmosphere_level, output ready);
endinterface

interface lebc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] brightness;

	modport source(output valid, brightness, input ready);
	modport sink(input valid, brightness, output ready);
endinterface

// ===== rtl/led_effect_brightness_core.sv =====
// Throughput: one LED per cycle while the result side accepts; the 32-stage remainder
// chain and the 8-stage quotient chain are fully pipelined, so no unit is shared
// between items.
// Reset: arst_n clears all stage valid bits and sets the atmosphere blend register to
// zero; stage data registers are not reset.
module led_effect_brightness_core (
	input  logic          clk,
	input  logic          arst_n,
	lebc_item_if.sink     item,
	lebc_result_if.source result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import lebc_pkg::*;

	// Configuration register. Only the single mix register exists; a write to
	// any other word address is dropped.
	logic [6:0] mix_q;
	logic [6:0] mix_sat;
	logic       wr_en;
	reg_idx_t   widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q <= '0;
		end else if (wr_en && widx == REG_MIX) begin
			mix_q <= pwdata[6:0];
		end
	end

	// Read back the stored value; unmapped words read as zero.
	always_comb begin
		case (widx)
			REG_MIX: prdata = {25'd0, mix_q};
			default: prdata = '0;
		endcase
	end

	// Mix settings beyond one hundred percent act as a full atmosphere blend.
	assign mix_sat = (mix_q > MixMax) ? MixMax : mix_q;

	// The datapath: period and duration setup, the elapsed-time remainder,
	// the quotient chain shared by the breath and shallow phase and the linear ramps, then the
	// easing curve, envelope scaling, and the atmosphere blend. Each stage
	// holds its beat until the next stage can take it, so a stall at the
	// output fills the empty stages before the input sees back-pressure.
	lebc_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.mix    (mix_sat),
		.item   (item),
		.result (result)
	);

endmodule

// ===== rtl/lebc_pipe.sv =====
module lebc_pipe (
	input logic         clk,
	input logic         arst_n,
	input logic [6:0]   mix,
	lebc_item_if.sink   item,
	lebc_result_if.source result
);
	import lebc_pkg::*;

	item_t pl_s [NumStages];
	item_t nxt  [NumStages];
	logic [NumStages-1:0] vld_q;
	logic [NumStages-1:0] ld;

	// A stage loads when it is empty or its content moves on.
	assign ld[NumStages-1] = !vld_q[NumStages-1] || result.ready;
	for (genvar k = 0; k < NumStages - 1; k++) begin : g_ld
		assign ld[k] = !vld_q[k] || ld[k+1];
	end

	assign item.ready        = ld[0];
	assign result.valid      = vld_q[NumStages-1];
	assign result.brightness = pl_s[NumStages-1].res;

	for (genvar k = 0; k < NumStages; k++) begin : g_stg
		if (k == StgLoad) begin : g_load
			always_comb begin
				logic [11:0] sp;
				logic [11:0] bp;
				logic [11:0] pp;
				item_t n;
				sp = {4'd0, item.speed};
				bp = 12'd3200 - (sp << 3) - (sp << 1);
				pp = 12'd1700 - (sp << 2);
				n = '0;
				n.kind    = item.effect_kind;
				n.value   = item.peak_value;
				n.phase   = item.phase_offset;
				n.elapsed = item.elapsed_ms;
				n.atm     = item.atmosphere_level;
				if (kind_t'(item.effect_kind) == KIND_PULSE) begin
					n.period = (pp < 12'd700) ? 12'd700 : pp;
				end else begin
					n.period = (bp < 12'd650) ? 12'd650 : bp;
				end
				if (item.duration_cs == 16'd0) begin
					n.dur = (kind_t'(item.effect_kind) == KIND_RISE) ? 20'd600 : 20'd250;
				end else begin
					n.dur = 20'({item.duration_cs, 3'b0}) + 20'({item.duration_cs, 1'b0});
				end
				nxt[k] = n;
			end
		end else if (k == StgPrep) begin : g_prep
			always_comb begin
				logic [19:0] pm;
				logic [41:0] rm;
				item_t n;
				n  = pl_s[k-1];
				pm = 20'(n.phase) * 20'(n.period);
				rm = 42'(n.dur) * 42'(3355444);
				n.dvd  = (kind_t'(n.kind) == KIND_PULSE) ? n.elapsed + 32'(pm[19:8]) : n.elapsed;
				n.rise = rm[40:24];
				n.rem  = '0;
				nxt[k] = n;
			end
		end else if (k >= StgRemLo && k <= StgRemHi) begin : g_rem
			// One remainder bit per stage, dividend taken from its top.
			always_comb begin
				logic [12:0] t;
				item_t n;
				n = pl_s[k-1];
				t = {n.rem, n.dvd[31]};
				if (t >= {1'b0, n.period}) begin
					n.rem = 12'(t - {1'b0, n.period});
				end else begin
					n.rem = t[11:0];
				end
				n.dvd  = n.dvd << 1;
				nxt[k] = n;
			end
		end else if (k == StgQSetup) begin : g_qset
			always_comb begin
				logic [19:0] left;
				logic [11:0] pos;
				logic [7:0]  x;
				item_t n;
				n    = pl_s[k-1];
				left = n.dur - n.elapsed[19:0];
				pos  = n.rem;
				n.quo  = '0;
				n.zero = n.elapsed >= 32'(n.dur);
				n.num  = 28'({n.rem, 8'd0});
				n.den  = 20'(n.period);
				case (kind_t'(n.kind))
					KIND_RISE: begin
						if (n.elapsed < 32'(n.rise)) begin
							n.num = 28'(n.value) * 28'(n.elapsed[16:0]);
							n.den = 20'(n.rise);
						end else begin
							n.num = 28'(n.value) * 28'(left);
							n.den = n.dur - 20'(n.rise);
						end
					end
					KIND_PRESS: begin
						n.num = 28'(n.value) * 28'(left);
						n.den = n.dur;
					end
					default: begin
					end
				endcase
				n.pact = 1'b0;
				x      = '0;
				if (pos < 12'd180) begin
					n.pact = 1'b1;
					x      = pos[7:0];
				end else if (pos >= 12'd280 && pos < 12'd460) begin
					n.pact = 1'b1;
					x      = 8'(pos - 12'd280);
				end
				n.pmul = 16'({x, 8'd0}) - 16'(x);
				nxt[k] = n;
			end
		end else if (k >= StgQLo && k <= StgQHi) begin : g_quo
			// Restoring division, one quotient bit per stage, MSB first.
			localparam int Sh = StgQHi - k;
			logic [7:0] pidx;
			if (k == StgQLo) begin : g_pidx
				// Pulse curve index pos*255/180 by a reciprocal multiply.
				logic [32:0] pp;
				assign pp   = 33'(pl_s[k-1].pmul) * 33'(93207);
				assign pidx = pp[31:24];
			end else begin : g_pidx_keep
				assign pidx = pl_s[k-1].pidx;
			end
			always_comb begin
				logic [27:0] ds;
				item_t n;
				n  = pl_s[k-1];
				ds = 28'(n.den) << Sh;
				if (n.num >= ds) begin
					n.num     = n.num - ds;
					n.quo[Sh] = 1'b1;
				end
				n.pidx = pidx;
				nxt[k] = n;
			end
		end else if (k == StgTri) begin : g_tri
			always_comb begin
				logic [7:0] p;
				logic [7:0] t;
				item_t n;
				n    = pl_s[k-1];
				p    = (kind_t'(n.kind) == KIND_PULSE) ? n.pidx : n.quo + n.phase;
				t    = tri8(p);
				n.sq = 16'(t) * 16'(t);
				nxt[k] = n;
			end
		end else if (k == StgEase) begin : g_ease
			always_comb begin
				item_t n;
				n      = pl_s[k-1];
				n.ease = div255(n.sq + 16'd255);
				nxt[k] = n;
			end
		end else if (k == StgScale) begin : g_scale
			always_comb begin
				item_t n;
				n     = pl_s[k-1];
				n.scl = 16'(n.ease) * ((kind_t'(n.kind) == KIND_BREATH) ? 16'd223 : 16'd89);
				nxt[k] = n;
			end
		end else if (k == StgLevel) begin : g_level
			always_comb begin
				item_t n;
				n = pl_s[k-1];
				if (kind_t'(n.kind) == KIND_PULSE) begin
					n.lvl = n.pact ? n.ease : 8'd0;
				end else begin
					n.lvl = div255(n.scl) +
						((kind_t'(n.kind) == KIND_BREATH) ? 8'd32 : 8'd166);
				end
				nxt[k] = n;
			end
		end else if (k == StgProd) begin : g_prod
			always_comb begin
				item_t n;
				n      = pl_s[k-1];
				n.prod = 16'(n.value) * 16'(n.lvl);
				nxt[k] = n;
			end
		end else if (k == StgEnv) begin : g_env
			always_comb begin
				item_t n;
				n = pl_s[k-1];
				case (kind_t'(n.kind))
					KIND_SOLID:   n.env = n.value;
					KIND_BREATH,
					KIND_SHALLOW,
					KIND_PULSE:   n.env = div255(n.prod);
					KIND_RISE,
					KIND_PRESS:   n.env = n.zero ? 8'd0 : n.quo;
					default:      n.env = 8'd0;
				endcase
				nxt[k] = n;
			end
		end else if (k == StgBlend) begin : g_blend
			always_comb begin
				item_t n;
				n       = pl_s[k-1];
				n.blend = 15'(n.env) * 15'(MixMax - mix) + 15'(n.atm) * 15'(mix);
				nxt[k] = n;
			end
		end else begin : g_out
			always_comb begin
				item_t n;
				n     = pl_s[k-1];
				n.res = (kind_t'(n.kind) == KIND_OFF) ? 8'd0 : div100(n.blend);
				nxt[k] = n;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (ld[k]) begin
				vld_q[k] <= (k == StgLoad) ? item.valid : vld_q[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				pl_s[k] <= nxt[k];
			end
		end
	end

endmodule
